### rtl/core/i2c_master_transfer_sequencer_core_assert.svh
// assertion macros used by the sequencer port checker
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SEQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define SEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### rtl/core/i2cms_pkg.sv
// shared types and constants of the i2c master transfer sequencer
`default_nettype none

package i2cms_pkg;

    localparam int TX_DEPTH_DEF = 32;
    localparam int Q_DEPTH      = 2;

    // opcodes
    localparam logic [1:0] OP_STATUS = 2'd0;
    localparam logic [1:0] OP_ERROR  = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;
    localparam logic [1:0] OP_ARM    = 2'd3;

    // configuration register indexes
    localparam logic REG_SLAVE_ADDRESS = 1'b0;
    localparam logic REG_TRANSMIT_DIR  = 1'b1;

    // status register one bits
    localparam logic [15:0] SR_SB      = 16'h0001;
    localparam logic [15:0] SR_ADDR    = 16'h0002;
    localparam logic [15:0] SR_TXE_BTF = 16'h0084;
    localparam logic [15:0] SR_TXE     = 16'h0080;
    localparam logic [15:0] SR_RXNE    = 16'h0040;
    localparam logic [15:0] SR_AF      = 16'h0400;
    localparam logic [15:0] SR_ARLO    = 16'h0200;
    localparam logic [15:0] SR_BERR    = 16'h0100;
    localparam logic [15:0] SR_OVR     = 16'h0800;

    // flag clear masks
    localparam logic [15:0] MASK_NONE = 16'hFFFF;
    localparam logic [15:0] MASK_AF   = 16'hFBFF;
    localparam logic [15:0] MASK_ARLO = 16'hFDFF;
    localparam logic [15:0] MASK_BERR = 16'hFEFF;
    localparam logic [15:0] MASK_OVR  = 16'hF7FF;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_SUCCESS = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        K_LOAD,
        K_ARM,
        K_START,
        K_ADDR,
        K_TXE,
        K_BTF,
        K_RXNE,
        K_IDLE,
        K_NOMASTER,
        K_ERROR
    } t_kind;

    // classified transfer handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  arg;
        logic [4:0]  index;
        logic [15:0] err_mask;
        logic        err_stop;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/core/i2cms_front.sv
// front part: accepts input transfers and classifies them into commands
`default_nettype none

module i2cms_front (
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [1:0]      i_opcode,
    input  wire logic [15:0]     i_status_flags,
    input  wire logic            i_master_mode,
    input  wire logic [7:0]      i_rx_data,
    input  wire logic [4:0]      i_load_index,
    input  wire logic [7:0]      i_load_data,
    input  wire logic [7:0]      i_transfer_length,
    input  wire logic            i_full,
    output logic                 o_push,
    output i2cms_pkg::t_cmd      o_cmd
);
    import i2cms_pkg::*;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd          = '0;
        o_cmd.kind     = K_IDLE;
        o_cmd.index    = i_load_index;
        o_cmd.err_mask = MASK_NONE;
        case (i_opcode)
            OP_LOAD: begin
                o_cmd.kind = K_LOAD;
                o_cmd.arg  = i_load_data;
            end
            OP_ARM: begin
                o_cmd.kind = K_ARM;
                o_cmd.arg  = i_transfer_length;
            end
            OP_STATUS: begin
                if ((i_status_flags & SR_SB) != '0) begin
                    o_cmd.kind = K_START;
                end else if (!i_master_mode) begin
                    o_cmd.kind = K_NOMASTER;
                end else if ((i_status_flags & SR_ADDR) != '0) begin
                    o_cmd.kind = K_ADDR;
                end else if ((i_status_flags & SR_TXE_BTF) == SR_TXE) begin
                    o_cmd.kind = K_TXE;
                end else if ((i_status_flags & SR_TXE_BTF) == SR_TXE_BTF) begin
                    o_cmd.kind = K_BTF;
                end else if ((i_status_flags & SR_RXNE) != '0) begin
                    o_cmd.kind = K_RXNE;
                    o_cmd.arg  = i_rx_data;
                end else begin
                    o_cmd.kind = K_IDLE;
                end
            end
            OP_ERROR: begin
                o_cmd.kind = K_ERROR;
                // first flag found wins, af also asks for stop
                if ((i_status_flags & SR_AF) != '0) begin
                    o_cmd.err_mask = MASK_AF;
                    o_cmd.err_stop = 1'b1;
                end else if ((i_status_flags & SR_ARLO) != '0) begin
                    o_cmd.err_mask = MASK_ARLO;
                end else if ((i_status_flags & SR_BERR) != '0) begin
                    o_cmd.err_mask = MASK_BERR;
                end else if ((i_status_flags & SR_OVR) != '0) begin
                    o_cmd.err_mask = MASK_OVR;
                end else begin
                    o_cmd.err_mask = MASK_NONE;
                end
            end
            default: begin
                o_cmd.kind = K_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/i2cms_queue.sv
// short command queue between front and back
`default_nettype none

module i2cms_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire i2cms_pkg::t_cmd i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_head_valid,
    output i2cms_pkg::t_cmd      o_head
);
    import i2cms_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_entry [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full       = (r_count == CNT_W'(Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/core/i2cms_back.sv
// back part: carries out commands, holds transfer state and the result register
`default_nettype none

module i2cms_back #(
    parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_index,
    input  wire logic [7:0]      i_cfg_data,
    input  wire logic            i_head_valid,
    input  wire i2cms_pkg::t_cmd i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic                 o_data_write,
    output logic [7:0]           o_data_value,
    output logic                 o_rx_valid,
    output logic [7:0]           o_rx_byte,
    output logic [7:0]           o_rx_position,
    output logic                 o_stop_request,
    output logic                 o_ack_disable,
    output logic                 o_buffer_irq_off,
    output logic                 o_event_irq_off,
    output logic [15:0]          o_flag_clear_mask,
    output logic                 o_bus_reset,
    output logic [1:0]           o_transfer_status
);
    import i2cms_pkg::*;

    localparam int PTR_W = $clog2(TX_DEPTH);

    // configuration
    logic [7:0]       r_slave;
    logic             r_dir;

    // transfer state
    logic [7:0]       r_count;
    logic [PTR_W-1:0] r_tx_ptr;
    logic [7:0]       r_rx_ptr;
    logic [7:0]       n_count;
    logic [PTR_W-1:0] n_tx_ptr;
    logic [7:0]       n_rx_ptr;
    logic [7:0]       count_dec;

    // transmit buffer
    logic [7:0]       r_mem [TX_DEPTH];
    logic [7:0]       r_rd_data;
    logic [PTR_W-1:0] rd_addr;
    logic             mem_we;

    // result register
    logic             r_out_valid;
    logic             r_dw,   n_dw;
    logic [7:0]       r_dv,   n_dv;
    logic             r_msel, n_msel;
    logic             r_rv,   n_rv;
    logic [7:0]       r_rb,   n_rb;
    logic [7:0]       r_rp,   n_rp;
    logic             r_stop, n_stop;
    logic             r_ack,  n_ack;
    logic             r_buf,  n_buf;
    logic             r_evt,  n_evt;
    logic [15:0]      r_mask, n_mask;
    logic             r_bus,  n_bus;
    t_status          r_st,   n_st;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // result register frees up when empty or being taken
    assign o_pop     = i_head_valid && (!r_out_valid || !i_stall);
    assign count_dec = (r_count != '0) ? r_count - 8'd1 : '0;

    always_comb begin
        n_count  = r_count;
        n_tx_ptr = r_tx_ptr;
        n_rx_ptr = r_rx_ptr;
        rd_addr  = r_tx_ptr;
        mem_we   = 1'b0;
        n_dw     = 1'b0;
        n_dv     = '0;
        n_msel   = 1'b0;
        n_rv     = 1'b0;
        n_rb     = '0;
        n_rp     = '0;
        n_stop   = 1'b0;
        n_ack    = 1'b0;
        n_buf    = 1'b0;
        n_evt    = 1'b0;
        n_mask   = MASK_NONE;
        n_bus    = 1'b0;
        n_st     = ST_NONE;
        case (i_head.kind)
            K_LOAD: begin
                mem_we = (32'(i_head.index) < TX_DEPTH);
            end
            K_ARM: begin
                n_count = i_head.arg;
            end
            K_START: begin
                n_dw = 1'b1;
                n_dv = r_slave;
            end
            K_ADDR: begin
                if (r_dir) begin
                    // restart from the first buffered byte
                    rd_addr  = '0;
                    n_tx_ptr = ptr_next('0);
                    n_dw     = 1'b1;
                    n_msel   = 1'b1;
                    n_count  = count_dec;
                    n_buf    = (count_dec == '0);
                end else begin
                    n_rx_ptr = '0;
                    if (r_count == 8'd1) begin
                        n_ack  = 1'b1;
                        n_stop = 1'b1;
                    end
                end
            end
            K_TXE: begin
                if (r_count != '0) begin
                    n_dw     = 1'b1;
                    n_msel   = 1'b1;
                    n_tx_ptr = ptr_next(r_tx_ptr);
                    n_count  = r_count - 8'd1;
                    n_buf    = (r_count == 8'd1);
                end
            end
            K_BTF: begin
                n_stop = 1'b1;
                n_evt  = 1'b1;
            end
            K_RXNE: begin
                n_rv     = 1'b1;
                n_rb     = i_head.arg;
                n_rp     = r_rx_ptr;
                n_rx_ptr = r_rx_ptr + 8'd1;
                n_count  = count_dec;
                if (count_dec == 8'd1) begin
                    n_ack  = 1'b1;
                    n_stop = 1'b1;
                    n_st   = ST_SUCCESS;
                end
            end
            K_IDLE: begin
            end
            K_NOMASTER: begin
                n_bus = 1'b1;
            end
            K_ERROR: begin
                n_mask = i_head.err_mask;
                n_stop = i_head.err_stop;
                n_bus  = !i_head.err_stop;
                n_st   = ST_ERROR;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave     <= '0;
            r_dir       <= 1'b0;
            r_count     <= '0;
            r_tx_ptr    <= '0;
            r_rx_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SLAVE_ADDRESS: r_slave <= i_cfg_data;
                    REG_TRANSMIT_DIR:  r_dir   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (o_pop) begin
                r_count  <= n_count;
                r_tx_ptr <= n_tx_ptr;
                r_rx_ptr <= n_rx_ptr;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dw   <= n_dw;
            r_dv   <= n_dv;
            r_msel <= n_msel;
            r_rv   <= n_rv;
            r_rb   <= n_rb;
            r_rp   <= n_rp;
            r_stop <= n_stop;
            r_ack  <= n_ack;
            r_buf  <= n_buf;
            r_evt  <= n_evt;
            r_mask <= n_mask;
            r_bus  <= n_bus;
            r_st   <= n_st;
        end
    end

    // buffer: at most one write and one registered read per transfer
    always_ff @(posedge i_clk) begin
        if (o_pop && mem_we) begin
            r_mem[PTR_W'(i_head.index)] <= i_head.arg;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_data_write      = r_dw;
    assign o_data_value      = r_msel ? r_rd_data : r_dv;
    assign o_rx_valid        = r_rv;
    assign o_rx_byte         = r_rb;
    assign o_rx_position     = r_rp;
    assign o_stop_request    = r_stop;
    assign o_ack_disable     = r_ack;
    assign o_buffer_irq_off  = r_buf;
    assign o_event_irq_off   = r_evt;
    assign o_flag_clear_mask = r_mask;
    assign o_bus_reset       = r_bus;
    assign o_transfer_status = r_st;

endmodule

`default_nettype wire

### rtl/core/i2c_master_transfer_sequencer_core.sv
// top level of the i2c master transfer sequencer
//
//  channel   direction  handshake            contents
//  input     in         i_valid / o_stall    opcode, status flags, master flag, bytes
//  result    out        o_valid / i_stall    data write, received byte, controls, status
//  config    in         i_cfg_we             slave address, transmit direction
//
// one transfer per cycle sustained while the result is not stalled; a transfer is written into the queue
// when accepted, then moves into the result register once that is free, and is taken from there
// the transmit buffer read is registered together with the result
// reset clears counts, pointers, configuration and the queue; the buffer is not cleared
// a stalled result holds while the queue takes up to two more transfers
`default_nettype none

module i2c_master_transfer_sequencer_core #(
    parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [15:0] i_status_flags,
    input  wire logic        i_master_mode,
    input  wire logic [7:0]  i_rx_data,
    input  wire logic [4:0]  i_load_index,
    input  wire logic [7:0]  i_load_data,
    input  wire logic [7:0]  i_transfer_length,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_data_write,
    output logic [7:0]       o_data_value,
    output logic             o_rx_valid,
    output logic [7:0]       o_rx_byte,
    output logic [7:0]       o_rx_position,
    output logic             o_stop_request,
    output logic             o_ack_disable,
    output logic             o_buffer_irq_off,
    output logic             o_event_irq_off,
    output logic [15:0]      o_flag_clear_mask,
    output logic             o_bus_reset,
    output logic [1:0]       o_transfer_status
);
    import i2cms_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic head_valid;
    t_cmd cmd;
    t_cmd head;

    i2cms_front u_front (
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_status_flags    (i_status_flags),
        .i_master_mode     (i_master_mode),
        .i_rx_data         (i_rx_data),
        .i_load_index      (i_load_index),
        .i_load_data       (i_load_data),
        .i_transfer_length (i_transfer_length),
        .i_full            (full),
        .o_push            (push),
        .o_cmd             (cmd)
    );

    i2cms_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    i2cms_back #(
        .TX_DEPTH (TX_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_head_valid      (head_valid),
        .i_head            (head),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_data_write      (o_data_write),
        .o_data_value      (o_data_value),
        .o_rx_valid        (o_rx_valid),
        .o_rx_byte         (o_rx_byte),
        .o_rx_position     (o_rx_position),
        .o_stop_request    (o_stop_request),
        .o_ack_disable     (o_ack_disable),
        .o_buffer_irq_off  (o_buffer_irq_off),
        .o_event_irq_off   (o_event_irq_off),
        .o_flag_clear_mask (o_flag_clear_mask),
        .o_bus_reset       (o_bus_reset),
        .o_transfer_status (o_transfer_status)
    );

endmodule

`default_nettype wire

### rtl/core/i2cms_checker.sv
// port-level checks on the sequencer top level, bound to it
`default_nettype none

`include "i2c_master_transfer_sequencer_core_assert.svh"

module i2cms_port_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_data_write,
    input wire logic [7:0] o_data_value,
    input wire logic       o_rx_valid,
    input wire logic       o_stop_request,
    input wire logic       o_bus_reset,
    input wire logic [1:0] o_transfer_status
);
    import i2cms_pkg::*;

    logic err_seen;

    assign err_seen = o_valid && (o_transfer_status == ST_ERROR);

    // a stalled result stays put
    `SEQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data_value))

    // no data register write means a zero data value
    `SEQ_ASSERT_NOW(a_dv_zero, i_clk, i_rst_n, o_valid && !o_data_write, o_data_value == 8'd0)

    // a received byte never comes with a write or a bus reset
    `SEQ_ASSERT_NOW(a_rx_excl, i_clk, i_rst_n, o_valid && o_rx_valid, !o_data_write && !o_bus_reset)

    // an error either stops (acknowledge failure) or resets the bus
    `SEQ_ASSERT_NOW(a_err_act, i_clk, i_rst_n, err_seen, o_stop_request != o_bus_reset)

endmodule

bind i2c_master_transfer_sequencer_core i2cms_port_checker u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_data_write      (o_data_write),
    .o_data_value      (o_data_value),
    .o_rx_valid        (o_rx_valid),
    .o_stop_request    (o_stop_request),
    .o_bus_reset       (o_bus_reset),
    .o_transfer_status (o_transfer_status)
);

`default_nettype wire

### sim/i2cms_checker.sv
// result checker for the i2c master transfer sequencer: predicts every transfer and compares
module i2cms_checker
    import i2cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_status_flags,
    input  logic        i_master_mode,
    input  logic [7:0]  i_rx_data,
    input  logic [4:0]  i_load_index,
    input  logic [7:0]  i_load_data,
    input  logic [7:0]  i_transfer_length,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic        o_data_write,
    input  logic [7:0]  o_data_value,
    input  logic        o_rx_valid,
    input  logic [7:0]  o_rx_byte,
    input  logic [7:0]  o_rx_position,
    input  logic        o_stop_request,
    input  logic        o_ack_disable,
    input  logic        o_buffer_irq_off,
    input  logic        o_event_irq_off,
    input  logic [15:0] o_flag_clear_mask,
    input  logic        o_bus_reset,
    input  logic [1:0]  o_transfer_status,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        data_write;
        logic [7:0]  data_value;
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic [7:0]  rx_position;
        logic        stop_request;
        logic        ack_disable;
        logic        buffer_irq_off;
        logic        event_irq_off;
        logic [15:0] flag_clear_mask;
        logic        bus_reset;
        t_status     transfer_status;
    } t_outcome;

    logic [7:0] tx_store [TX_DEPTH_DEF];
    logic [7:0] bytes_left = '0;
    logic [$clog2(TX_DEPTH_DEF)-1:0] tx_ptr = '0;
    logic [7:0] rx_ptr = '0;
    logic [7:0] slave_addr = '0;
    logic       tx_dir = 1'b0;

    t_outcome expected_q[$];
    int pending = 0;
    int failures = 0;

    assign o_pending = pending;
    assign o_fail_count = failures;

    function automatic logic [7:0] fetch_tx_byte();
        logic [7:0] b;
        b = tx_store[tx_ptr];
        tx_ptr++;
        return b;
    endfunction

    function automatic string describe(input t_outcome r);
        return $sformatf("dw=%0d dv=%02h rv=%0d rb=%02h rp=%02h stop=%0d ack=%0d buf=%0d evt=%0d mask=%04h rst=%0d st=%0d",
            r.data_write, r.data_value, r.rx_valid, r.rx_byte, r.rx_position,
            r.stop_request, r.ack_disable, r.buffer_irq_off, r.event_irq_off,
            r.flag_clear_mask, r.bus_reset, r.transfer_status);
    endfunction

    task automatic predict_outcome(input logic [1:0] op, input logic [15:0] sr,
                                   input logic master, input logic [7:0] rxd,
                                   input logic [4:0] lidx, input logic [7:0] ldat,
                                   input logic [7:0] tlen, output t_outcome r);
        r = '0;
        r.flag_clear_mask = MASK_NONE;
        r.transfer_status = ST_NONE;
        case (op)
            OP_LOAD: tx_store[lidx] = ldat;
            OP_ARM:  bytes_left = tlen;
            OP_STATUS: begin
                if ((sr & SR_SB) != '0) begin
                    r.data_write = 1'b1;
                    r.data_value = slave_addr;
                end else if (!master) begin
                    r.bus_reset = 1'b1;
                end else if ((sr & SR_ADDR) != '0) begin
                    if (tx_dir) begin
                        tx_ptr = '0;
                        r.data_write = 1'b1;
                        r.data_value = fetch_tx_byte();
                        // count saturates, a byte still goes out at zero
                        if (bytes_left != '0) bytes_left--;
                        r.buffer_irq_off = (bytes_left == '0);
                    end else begin
                        rx_ptr = '0;
                        if (bytes_left == 8'd1) begin
                            r.ack_disable = 1'b1;
                            r.stop_request = 1'b1;
                        end
                    end
                end else if ((sr & SR_TXE_BTF) == SR_TXE) begin
                    if (bytes_left != '0) begin
                        r.data_write = 1'b1;
                        r.data_value = fetch_tx_byte();
                        bytes_left--;
                        r.buffer_irq_off = (bytes_left == '0);
                    end
                end else if ((sr & SR_TXE_BTF) == SR_TXE_BTF) begin
                    r.stop_request = 1'b1;
                    r.event_irq_off = 1'b1;
                end else if ((sr & SR_RXNE) != '0) begin
                    r.rx_valid = 1'b1;
                    r.rx_byte = rxd;
                    r.rx_position = rx_ptr;
                    rx_ptr++;
                    if (bytes_left != '0) bytes_left--;
                    if (bytes_left == 8'd1) begin
                        r.ack_disable = 1'b1;
                        r.stop_request = 1'b1;
                        r.transfer_status = ST_SUCCESS;
                    end
                end
            end
            default: begin
                // error event: only the first flag found is cleared
                if ((sr & SR_AF) != '0) begin
                    r.flag_clear_mask = MASK_AF;
                    r.stop_request = 1'b1;
                end else begin
                    if ((sr & SR_ARLO) != '0)
                        r.flag_clear_mask = MASK_ARLO;
                    else if ((sr & SR_BERR) != '0)
                        r.flag_clear_mask = MASK_BERR;
                    else if ((sr & SR_OVR) != '0)
                        r.flag_clear_mask = MASK_OVR;
                    r.bus_reset = 1'b1;
                end
                r.transfer_status = ST_ERROR;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (!i_rst_n) begin
            bytes_left = '0;
            tx_ptr = '0;
            rx_ptr = '0;
            slave_addr = '0;
            tx_dir = 1'b0;
            expected_q.delete();
            pending <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                got.data_write = o_data_write;
                got.data_value = o_data_value;
                got.rx_valid = o_rx_valid;
                got.rx_byte = o_rx_byte;
                got.rx_position = o_rx_position;
                got.stop_request = o_stop_request;
                got.ack_disable = o_ack_disable;
                got.buffer_irq_off = o_buffer_irq_off;
                got.event_irq_off = o_event_irq_off;
                got.flag_clear_mask = o_flag_clear_mask;
                got.bus_reset = o_bus_reset;
                got.transfer_status = t_status'(o_transfer_status);
                if (expected_q.size() == 0) begin
                    if (failures < 10)
                        $display("%0t: result with no transfer pending: %s", $time, describe(got));
                    failures++;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (failures < 10)
                            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                     $time, describe(want), describe(got));
                        failures++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SLAVE_ADDRESS)
                    slave_addr = i_cfg_data;
                else
                    tx_dir = i_cfg_data[0];
            end
            if (i_valid && !o_stall) begin
                predict_outcome(i_opcode, i_status_flags, i_master_mode, i_rx_data,
                                i_load_index, i_load_data, i_transfer_length, want);
                expected_q.push_back(want);
            end
            pending <= expected_q.size();
        end
    end

endmodule

### sim/tb.sv
// testbench top for the i2c master transfer sequencer: stimulus, flow control and verdict
module tb;
    import i2cms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 60;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 100;
    localparam int RX_STREAM    = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = OP_LOAD;
    logic [15:0] i_status_flags = '0;
    logic        i_master_mode = 1'b0;
    logic [7:0]  i_rx_data = '0;
    logic [4:0]  i_load_index = '0;
    logic [7:0]  i_load_data = '0;
    logic [7:0]  i_transfer_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_data_write;
    logic [7:0]  o_data_value;
    logic        o_rx_valid;
    logic [7:0]  o_rx_byte;
    logic [7:0]  o_rx_position;
    logic        o_stop_request;
    logic        o_ack_disable;
    logic        o_buffer_irq_off;
    logic        o_event_irq_off;
    logic [15:0] o_flag_clear_mask;
    logic        o_bus_reset;
    logic [1:0]  o_transfer_status;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned gap_rate = 2;
    logic calm = 1'b0;
    logic hold_now = 1'b0;
    logic tx_mode = 1'b0;

    i2c_master_transfer_sequencer_core u_top (.*);

    i2cms_checker u_check (.*, .o_pending(pending), .o_fail_count(fail_count));

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // result side back-pressure: random bursts, quiet stretches, one long hold-off
    initial begin : result_stall
        int unsigned busy, free;
        busy = 0;
        free = 0;
        forever begin
            @(posedge i_clk);
            if (hold_now) begin
                hold_now = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (calm) begin
                i_stall <= 1'b0;
            end else if (busy != 0) begin
                i_stall <= 1'b1;
                busy--;
            end else if (free != 0) begin
                i_stall <= 1'b0;
                free--;
            end else if ($urandom_range(0, 2) == 0) begin
                busy = $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                free = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                    : $urandom_range(1, 12);
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic [15:0] flags_with(input logic [15:0] set_bits,
                                               input logic [15:0] clear_bits);
        return (16'($urandom) & ~clear_bits) | set_bits;
    endfunction

    task automatic offer(input logic [1:0] op, input logic [15:0] sr, input logic msl,
                         input logic [7:0] rxd, input logic [4:0] lidx,
                         input logic [7:0] ldat, input logic [7:0] tlen);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_status_flags <= sr;
        i_master_mode <= msl;
        i_rx_data <= rxd;
        i_load_index <= lidx;
        i_load_data <= ldat;
        i_transfer_length <= tlen;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (!calm && gap_rate != 0 && $urandom_range(1, 16) <= gap_rate) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic put_status(input logic [15:0] sr, input logic msl, input logic [7:0] rxd);
        offer(OP_STATUS, sr, msl, rxd, 5'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic put_error(input logic [15:0] sr);
        offer(OP_ERROR, sr, 1'($urandom), 8'($urandom), 5'($urandom), 8'($urandom),
              8'($urandom));
    endtask

    task automatic put_load(input logic [4:0] idx, input logic [7:0] data);
        offer(OP_LOAD, 16'($urandom), 1'($urandom), 8'($urandom), idx, data, 8'($urandom));
    endtask

    task automatic put_arm(input logic [7:0] len);
        offer(OP_ARM, 16'($urandom), 1'($urandom), 8'($urandom), 5'($urandom),
              8'($urandom), len);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_registers(input logic [7:0] addr, input logic dir);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_SLAVE_ADDRESS;
        i_cfg_data <= addr;
        @(posedge i_clk);
        i_cfg_index <= REG_TRANSMIT_DIR;
        i_cfg_data <= {7'd0, dir};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tx_mode = dir;
    endtask

    // optional loads and an arm, then start, address, data bytes and byte transfer finished
    task automatic tx_sequence();
        int unsigned len, k;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 6);
        repeat ($urandom_range(0, 2)) put_load(5'($urandom), 8'($urandom));
        put_arm(8'(len));
        put_status(flags_with(SR_SB, 16'h0000), 1'b1, 8'($urandom));
        put_status(flags_with(SR_ADDR, SR_SB), 1'b1, 8'($urandom));
        for (k = 1; k < len; k++) begin
            if ($urandom_range(0, 39) == 0) put_error(16'($urandom));
            put_status(flags_with(SR_TXE, SR_SB | SR_ADDR | SR_TXE_BTF), 1'b1, 8'($urandom));
        end
        if ($urandom_range(0, 3) == 0)
            put_status(flags_with(SR_TXE, SR_SB | SR_ADDR | SR_TXE_BTF), 1'b1, 8'($urandom));
        put_status(flags_with(SR_TXE_BTF, SR_SB | SR_ADDR), 1'b1, 8'($urandom));
    endtask

    task automatic rx_sequence();
        int unsigned len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 5);
        put_arm(8'(len));
        put_status(flags_with(SR_SB, 16'h0000), 1'b1, 8'($urandom));
        put_status(flags_with(SR_ADDR, SR_SB), 1'b1, 8'($urandom));
        repeat (len) begin
            if ($urandom_range(0, 39) == 0) put_error(16'($urandom));
            put_status(flags_with(SR_RXNE, SR_SB | SR_ADDR | SR_TXE), 1'b1, 8'($urandom));
        end
    endtask

    task automatic run_phase(input int unsigned quota);
        int unsigned stop_at;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0) gap_rate = $urandom_range(0, 4);
            case ($urandom_range(0, 9))
                0, 1, 2: offer(2'($urandom), 16'($urandom), 1'($urandom), 8'($urandom),
                               5'($urandom), 8'($urandom), 8'($urandom));
                default: begin
                    // mostly sequences that match the direction, now and then the other
                    if (tx_mode ^ ($urandom_range(0, 7) == 0))
                        tx_sequence();
                    else
                        rx_sequence();
                end
            endcase
        end
    endtask

    initial begin : stimulus
        int p;
        logic [7:0] addr;
        logic dir;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // transmitter: short transfer, count at zero, no master, error priority
        set_registers(8'hFF, 1'b1);
        put_load(5'd0, 8'hFF);
        put_load(5'd31, 8'h00);
        put_load(5'd1, 8'hA5);
        put_load(5'd2, 8'h5A);
        put_arm(8'd3);
        put_status(SR_SB, 1'b0, 8'h00);
        put_status(SR_ADDR, 1'b1, 8'h00);
        put_status(SR_TXE, 1'b1, 8'h00);
        put_status(SR_TXE, 1'b1, 8'h00);
        put_status(SR_TXE, 1'b1, 8'h00);
        put_status(SR_TXE_BTF, 1'b1, 8'h00);
        put_status(SR_ADDR, 1'b1, 8'h00);
        put_status(16'hFFFE, 1'b0, 8'hFF);
        put_status(16'h0000, 1'b1, 8'h00);
        put_error(16'hFFFF);
        put_error(SR_ARLO | SR_BERR | SR_OVR);
        put_error(SR_BERR | SR_OVR);
        put_error(SR_OVR);
        put_error(16'h0000);

        // receiver: single byte, then last-but-one byte and the last byte
        wait_drained();
        set_registers(8'h00, 1'b0);
        put_arm(8'd1);
        put_status(SR_ADDR, 1'b1, 8'h00);
        put_status(SR_RXNE, 1'b1, 8'hFF);
        put_arm(8'd3);
        put_status(SR_RXNE, 1'b1, 8'h00);
        put_status(SR_RXNE, 1'b1, 8'h5A);
        put_status(SR_RXNE, 1'b1, 8'hA5);

        // every buffer entry written before random traffic can read it
        for (p = 0; p < TX_DEPTH_DEF; p++) put_load(p[4:0], 8'($urandom));

        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin addr = 8'h00; dir = 1'b1; end
                1: begin addr = 8'hFF; dir = 1'b0; end
                default: begin addr = 8'($urandom); dir = 1'($urandom); end
            endcase
            set_registers(addr, dir);
            if (p == 1) begin
                // long receive run so the receive index wraps
                put_arm(8'hFF);
                repeat (RX_STREAM)
                    put_status(flags_with(SR_RXNE, SR_SB | SR_ADDR | SR_TXE), 1'b1,
                               8'($urandom));
            end
            if (p == 3) begin
                gap_rate = 0;
                hold_now = 1'b1;
            end
            if (p == PHASES - 1) calm = 1'b1;
            run_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
